/* src/wsfr_pkg.sv */
// shared types and constants for the websocket frame receive / unmask block
// no dependencies; imported by every module of the block
package wsfr_pkg;

	localparam int LEN_W         = 63;
	localparam int QUEUE_DEPTH   = 4;
	localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(10485760);

	// result kinds
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_EMPTY   = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	// header byte constants
	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;

	// classified item passed from the parser to the output side
	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       data;
		logic [7:0]       key;
		logic [3:0]       opcode;
		logic [LEN_W-1:0] length;
		logic             last;
	} tok_t;

	localparam int TOK_W = $bits(tok_t);

endpackage

/* src/wsfr_front.sv */
// header parser: takes raw stream bytes, tracks frame state and emits tokens
// depends on wsfr_pkg
module wsfr_front
	import wsfr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wen,
	input  logic [LEN_W-1:0] cfg_wdata,
	input  logic             byte_valid,
	output logic             byte_ready,
	input  logic [7:0]       in_byte,
	input  logic             tok_ready,
	output logic             tok_valid,
	output tok_t             tok
);

	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_EXTLEN,
		PH_KEY,
		PH_DATA,
		PH_DEAD
	} phase_t;

	phase_t           phase_q;
	logic [3:0]       opcode_q;
	logic             masked_q;
	logic [2:0]       len_cnt_q;
	logic [63:0]      len_q;
	logic [31:0]      key_q;
	logic [1:0]       key_cnt_q;
	logic [63:0]      rem_q;
	logic [1:0]       key_pos_q;
	logic [LEN_W-1:0] max_len_q;

	logic        fire;
	logic [63:0] len_chk;
	logic        over;
	logic        zero;
	logic        hdr_done;
	logic        masked_chk;
	logic [7:0]  key_byte;
	logic        data_last;

	assign byte_ready = tok_ready;
	assign fire       = byte_valid && byte_ready;

	// length that the header check looks at this cycle
	always_comb begin
		len_chk    = len_q;
		masked_chk = masked_q;
		hdr_done   = 1'b0;
		case (phase_q)
			PH_HDR1: begin
				len_chk    = {57'd0, in_byte[6:0]};
				masked_chk = in_byte[7];
				hdr_done   = (in_byte[6:0] < LEN7_EXT16) && !in_byte[7];
			end
			PH_EXTLEN: begin
				len_chk  = {len_q[55:0], in_byte};
				hdr_done = (len_cnt_q == 3'd0) && !masked_q;
			end
			PH_KEY: begin
				hdr_done = (key_cnt_q == 2'd3);
			end
			default: begin
				hdr_done = 1'b0;
			end
		endcase
	end

	assign over = len_chk > {1'b0, max_len_q};
	assign zero = len_chk == 64'd0;

	always_comb begin
		case (key_pos_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	assign data_last = rem_q <= 64'd1;

	always_comb begin
		tok_valid   = 1'b0;
		tok.kind    = KIND_PAYLOAD;
		tok.data    = 8'd0;
		tok.key     = 8'd0;
		tok.opcode  = opcode_q;
		tok.length  = len_chk[LEN_W-1:0];
		tok.last    = 1'b1;
		if (phase_q == PH_DATA) begin
			tok_valid = byte_valid;
			tok.data  = in_byte;
			tok.key   = masked_q ? key_byte : 8'd0;
			tok.last  = data_last;
		end else if (hdr_done && (over || zero)) begin
			tok_valid = byte_valid;
			tok.kind  = over ? KIND_ERROR : KIND_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HDR0;
			opcode_q  <= 4'd0;
			masked_q  <= 1'b0;
			len_cnt_q <= 3'd0;
			len_q     <= 64'd0;
			key_q     <= 32'd0;
			key_cnt_q <= 2'd0;
			rem_q     <= 64'd0;
			key_pos_q <= 2'd0;
			max_len_q <= MAX_LEN_RESET;
		end else begin
			if (cfg_wen) begin
				max_len_q <= cfg_wdata;
			end
			if (fire) begin
				case (phase_q)
					PH_HDR0: begin
						opcode_q  <= in_byte[3:0];
						masked_q  <= 1'b0;
						len_q     <= 64'd0;
						key_q     <= 32'd0;
						key_cnt_q <= 2'd0;
						key_pos_q <= 2'd0;
						rem_q     <= 64'd0;
						phase_q   <= PH_HDR1;
					end
					PH_HDR1: begin
						masked_q <= in_byte[7];
						if (in_byte[6:0] < LEN7_EXT16) begin
							len_q <= len_chk;
						end else begin
							len_q     <= 64'd0;
							len_cnt_q <= (in_byte[6:0] == LEN7_EXT64) ? 3'd7 : 3'd1;
							phase_q   <= PH_EXTLEN;
						end
					end
					PH_EXTLEN: begin
						len_q     <= len_chk;
						len_cnt_q <= len_cnt_q - 3'd1;
					end
					PH_KEY: begin
						key_q     <= {key_q[23:0], in_byte};
						key_cnt_q <= key_cnt_q + 2'd1;
					end
					PH_DATA: begin
						key_pos_q <= key_pos_q + 2'd1;
						rem_q     <= rem_q - 64'd1;
						if (data_last) begin
							phase_q <= PH_HDR0;
						end
					end
					default: begin
						phase_q <= PH_DEAD;
					end
				endcase
				// length known and masked: collect the key next
				if (masked_chk && ((phase_q == PH_HDR1 && in_byte[6:0] < LEN7_EXT16) ||
						(phase_q == PH_EXTLEN && len_cnt_q == 3'd0))) begin
					key_cnt_q <= 2'd0;
					key_q     <= 32'd0;
					phase_q   <= PH_KEY;
				end
				if (hdr_done) begin
					if (over) begin
						phase_q <= PH_DEAD;
					end else if (zero) begin
						phase_q <= PH_HDR0;
					end else begin
						rem_q     <= len_chk;
						key_pos_q <= 2'd0;
						phase_q   <= PH_DATA;
					end
				end
			end
		end
	end

endmodule

/* src/wsfr_queue.sv */
// small register queue between the parser and the output stage
// depends on wsfr_pkg
module wsfr_queue
	import wsfr_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  tok_t push_tok,
	output logic pop_valid,
	input  logic pop_ready,
	output tok_t pop_tok
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tok_t             ent_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic push;
	logic pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_tok    = ent_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

/* src/wsfr_back.sv */
// output stage: unmasks payload bytes and holds the result for the master side
// depends on wsfr_pkg
module wsfr_back
	import wsfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        tok_valid,
	output logic        tok_ready,
	input  tok_t        tok,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);

	logic             valid_q;
	logic [1:0]       kind_q;
	logic [7:0]       data_q;
	logic [3:0]       opcode_q;
	logic [LEN_W-1:0] length_q;
	logic             last_q;

	assign tok_ready = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (tok_ready) begin
			valid_q <= tok_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_ready && tok_valid) begin
			kind_q   <= tok.kind;
			data_q   <= tok.data ^ tok.key;
			opcode_q <= tok.opcode;
			length_q <= tok.length;
			last_q   <= tok.last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {5'd0, length_q, opcode_q, data_q};
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

endmodule

/* src/websocket_frame_receive_unmask_core.sv */
// top level of the websocket frame receive / unmask block
// depends on wsfr_pkg, wsfr_front, wsfr_queue, wsfr_back
//
// channel   dir  handshake          contents
// s_axis    in   s_tvalid/s_tready  s_tdata[7:0] in_byte
// m_axis    out  m_tvalid/m_tready  tdata: payload_byte, opcode, frame_length; tuser kind;
//                                   tlast last_of_frame
// cfg       in   cfg_wen            cfg_wdata max_payload_len
//
// one byte per cycle in while s_tready is high; each byte yields zero or one result,
// passed through a DEPTH-entry queue and one output register
// s_tready drops only when the queue is full, i.e. when m_tready has been low
// reset clears parser state and the limit to its default; no clearing pass
module websocket_frame_receive_unmask_core
	import wsfr_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wen,
	input  logic [LEN_W-1:0] cfg_wdata,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,  // in_byte
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [79:0]      m_tdata,  // payload_byte[7:0], opcode[11:8], frame_length[74:12]
	output logic [1:0]       m_tuser,  // kind
	output logic             m_tlast
);

	logic f_valid;
	logic f_ready;
	tok_t f_tok;
	logic b_valid;
	logic b_ready;
	tok_t b_tok;

	wsfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.byte_valid (s_tvalid),
		.byte_ready (s_tready),
		.in_byte    (s_tdata),
		.tok_ready  (f_ready),
		.tok_valid  (f_valid),
		.tok        (f_tok)
	);

	wsfr_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_tok   (f_tok),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_tok    (b_tok)
	);

	wsfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (b_valid),
		.tok_ready (b_ready),
		.tok       (b_tok),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
